// ===== hw/rtl/julia_escape_time_pixel_core_macros.svh =====
// Assertion macros for the Julia escape-time pixel core.
// Included by the modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define JETP_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("jetp check failed");
// next-cycle implication
`define JETP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("jetp check failed");
`else
`define JETP_ASSERT_IMPL(name, pre, post)
`define JETP_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== hw/rtl/jetp_pkg.sv =====
// Shared types and constants for the Julia escape-time pixel core.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package jetp_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int PIX_W       = 16;              // offsets and widened pixel coords
  localparam int DIV_BITS    = PIX_W + FRAC_BITS; // quotient bits
  localparam int DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int Z_W         = DIV_BITS + 2;    // signed z components
  localparam int SQ_IN_BITS  = 28;              // magnitude limit 16.0
  localparam int SQ_W        = 33;              // square, up to 256.0
  localparam int CROSS_W     = 34;              // 2*re*im magnitude
  localparam int COUNT_W     = 8;
  localparam int ITER_LIMIT  = 256;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic signed [Z_W-1:0] C_REAL = Z_W'(4781507);
  localparam logic signed [Z_W-1:0] C_IMAG = Z_W'(167772);
  localparam logic [CROSS_W-1:0] ESCAPE_R2 = CROSS_W'(4) << FRAC_BITS;

  localparam logic [CFG_W-1:0] COLUMN_OFFSET_RST = CFG_W'(80);
  localparam logic [CFG_W-1:0] ROW_OFFSET_RST    = CFG_W'(60);
  localparam logic [CFG_W-1:0] ZOOM_DIVISOR_RST  = CFG_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_OFFSET = 2'd0,
    CFG_ROW_OFFSET    = 2'd1,
    CFG_ZOOM_DIVISOR  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] column_offset;
    logic [CFG_W-1:0] row_offset;
    logic [CFG_W-1:0] zoom;           // zero already mapped to one
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_LOAD_IM,
    ST_DIV_IM,
    ST_LOAD_Z,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load_pixel;   // latch column, start row division
    logic div_step;     // one quotient bit
    logic load_im;      // store re, start column division
    logic store_im;     // store im, clear count
    logic mul;          // register squares and cross term
    logic upd;          // form next z, bump count
  } dp_cmd_t;

  typedef struct packed {
    logic more;         // another step follows the current update
  } dp_status_t;

endpackage

// ===== hw/rtl/jetp_cfg.sv =====
// Configuration register file: offsets and zoom divisor.
// Depends on jetp_pkg.
`timescale 1ns / 1ps

module jetp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [jetp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [jetp_pkg::CFG_W-1:0]    cfg_data_i,
  output jetp_pkg::cfg_t                cfg_o
);

  logic [jetp_pkg::CFG_W-1:0] col_off_q, col_off_d;
  logic [jetp_pkg::CFG_W-1:0] row_off_q, row_off_d;
  logic [jetp_pkg::CFG_W-1:0] zoom_q, zoom_d;

  always_comb begin
    col_off_d = col_off_q;
    row_off_d = row_off_q;
    zoom_d    = zoom_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jetp_pkg::CFG_COLUMN_OFFSET: col_off_d = cfg_data_i;
        jetp_pkg::CFG_ROW_OFFSET:    row_off_d = cfg_data_i;
        jetp_pkg::CFG_ZOOM_DIVISOR:  zoom_d    = cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_off_q <= jetp_pkg::COLUMN_OFFSET_RST;
      row_off_q <= jetp_pkg::ROW_OFFSET_RST;
      zoom_q    <= jetp_pkg::ZOOM_DIVISOR_RST;
    end else begin
      col_off_q <= col_off_d;
      row_off_q <= row_off_d;
      zoom_q    <= zoom_d;
    end
  end

  assign cfg_o.column_offset = col_off_q;
  assign cfg_o.row_offset    = row_off_q;
  assign cfg_o.zoom          = (zoom_q == '0) ? jetp_pkg::CFG_W'(1) : zoom_q;

endmodule

// ===== hw/rtl/jetp_ctrl.sv =====
// Sequencer for the pixel core: two divisions, then the square-and-add loop.
// Depends on jetp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_core_macros.svh"

module jetp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  jetp_pkg::dp_status_t status_i,
  output jetp_pkg::dp_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 result_valid_o
);

  jetp_pkg::ctrl_state_e state_q, state_d;
  logic [jetp_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic div_last;

  assign div_last = (div_cnt_q == jetp_pkg::DIV_CNT_W'(jetp_pkg::DIV_BITS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jetp_pkg::ST_IDLE:    if (start_i) state_d = jetp_pkg::ST_DIV_RE;
      jetp_pkg::ST_DIV_RE:  if (div_last) state_d = jetp_pkg::ST_LOAD_IM;
      jetp_pkg::ST_LOAD_IM: state_d = jetp_pkg::ST_DIV_IM;
      jetp_pkg::ST_DIV_IM:  if (div_last) state_d = jetp_pkg::ST_LOAD_Z;
      jetp_pkg::ST_LOAD_Z:  state_d = jetp_pkg::ST_MUL;
      jetp_pkg::ST_MUL:     state_d = jetp_pkg::ST_UPD;
      jetp_pkg::ST_UPD:     state_d = status_i.more ? jetp_pkg::ST_MUL : jetp_pkg::ST_DONE;
      jetp_pkg::ST_DONE:    state_d = jetp_pkg::ST_IDLE;
      default:              state_d = jetp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    div_cnt_d      = '0;
    unique case (state_q)
      jetp_pkg::ST_IDLE: begin
        busy_o           = 1'b0;
        cmd_o.load_pixel = start_i;
      end
      jetp_pkg::ST_DIV_RE, jetp_pkg::ST_DIV_IM: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_last ? '0 : div_cnt_q + 1'b1;
      end
      jetp_pkg::ST_LOAD_IM: cmd_o.load_im  = 1'b1;
      jetp_pkg::ST_LOAD_Z:  cmd_o.store_im = 1'b1;
      jetp_pkg::ST_MUL:     cmd_o.mul      = 1'b1;
      jetp_pkg::ST_UPD:     cmd_o.upd      = 1'b1;
      jetp_pkg::ST_DONE:    result_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= jetp_pkg::ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  `JETP_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o)
  `JETP_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && cmd_o.div_step)
  `JETP_ASSERT_NEXT(a_mul_then_upd, cmd_o.mul, cmd_o.upd)

endmodule

// ===== hw/rtl/jetp_dp.sv =====
// Datapath: shared restoring divider, square/cross-term multipliers, z update.
// Depends on jetp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_core_macros.svh"

module jetp_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     column_i,
  input  logic [6:0]                     row_i,
  input  jetp_pkg::cfg_t                 cfg_i,
  input  jetp_pkg::dp_cmd_t              cmd_i,
  output jetp_pkg::dp_status_t           status_o,
  output logic [jetp_pkg::COUNT_W-1:0]   escape_count_o
);

  localparam int PW = jetp_pkg::PIX_W;
  localparam int QW = jetp_pkg::DIV_BITS;
  localparam int ZW = jetp_pkg::Z_W;
  localparam int SB = jetp_pkg::SQ_IN_BITS;
  localparam int SW = jetp_pkg::SQ_W;
  localparam int XW = jetp_pkg::CROSS_W;
  localparam int CW = jetp_pkg::COUNT_W;

  function automatic logic signed [ZW-1:0] apply_sign(input logic neg,
                                                      input logic [QW-1:0] mag);
    logic signed [ZW-1:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

  logic [7:0]           col_q;
  logic [PW-1:0]        rem_q;
  logic [QW-1:0]        quo_q;
  logic                 neg_q;
  logic signed [ZW-1:0] re_q, im_q;
  logic [SW-1:0]        sr_q, si_q;
  logic [XW-1:0]        cross_q;
  logic                 cneg_q;
  logic [CW-1:0]        count_q, count_d;

  // divider start operands
  logic [PW-1:0] pix, off, diff;
  logic          pix_neg;
  always_comb begin
    pix     = cmd_i.load_pixel ? PW'(row_i) : PW'(col_q);
    off     = cmd_i.load_pixel ? cfg_i.row_offset : cfg_i.column_offset;
    pix_neg = off > pix;
    diff    = pix_neg ? (off - pix) : (pix - off);
  end

  // one restoring step
  logic [PW:0] trial;
  logic        ge;
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    ge    = trial >= {1'b0, cfg_i.zoom};
  end

  // squares and cross term from magnitudes
  logic [ZW-1:0]       mr, mi;
  logic                sat_r, sat_i;
  logic [2*SB-1:0]     sq_r, sq_i;
  logic [SB:0]         cr, ci;
  logic [2*SB+1:0]     cprod;
  always_comb begin
    mr    = re_q[ZW-1] ? ZW'(-re_q) : ZW'(re_q);
    mi    = im_q[ZW-1] ? ZW'(-im_q) : ZW'(im_q);
    sat_r = |mr[ZW-1:SB];
    sat_i = |mi[ZW-1:SB];
    sq_r  = mr[SB-1:0] * mr[SB-1:0];
    sq_i  = mi[SB-1:0] * mi[SB-1:0];
    cr    = sat_r ? {1'b1, SB'(0)} : {1'b0, mr[SB-1:0]};
    ci    = sat_i ? {1'b1, SB'(0)} : {1'b0, mi[SB-1:0]};
    cprod = cr * ci;
  end

  // update terms
  logic signed [ZW-1:0] sr_s, si_s, cross_s;
  logic [XW-1:0]        radius;
  logic [CW:0]          count_inc;
  always_comb begin
    sr_s      = $signed(ZW'(sr_q));
    si_s      = $signed(ZW'(si_q));
    cross_s   = $signed(ZW'(cross_q));
    radius    = XW'(sr_q) + XW'(si_q);
    count_inc = {1'b0, count_q} + 1'b1;
    status_o.more = (count_inc < (CW+1)'(jetp_pkg::ITER_LIMIT - 1)) &&
                    (radius < jetp_pkg::ESCAPE_R2);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pixel) col_q <= column_i;
    if (cmd_i.load_pixel || cmd_i.load_im) begin
      rem_q <= '0;
      quo_q <= {diff, jetp_pkg::FRAC_BITS'(0)};
      neg_q <= pix_neg;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? PW'(trial - {1'b0, cfg_i.zoom}) : trial[PW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
    if (cmd_i.load_im) re_q <= apply_sign(neg_q, quo_q);
    if (cmd_i.store_im) im_q <= apply_sign(neg_q, quo_q);
    if (cmd_i.mul) begin
      sr_q    <= sat_r ? {1'b1, (SW-1)'(0)} : {1'b0, sq_r[2*SB-1:jetp_pkg::FRAC_BITS]};
      si_q    <= sat_i ? {1'b1, (SW-1)'(0)} : {1'b0, sq_i[2*SB-1:jetp_pkg::FRAC_BITS]};
      cross_q <= cprod[2*SB:jetp_pkg::FRAC_BITS-1];   // times two, then >> 24
      cneg_q  <= re_q[ZW-1] ^ im_q[ZW-1];
    end
    if (cmd_i.upd) begin
      re_q <= sr_s - si_s + jetp_pkg::C_REAL;
      im_q <= (cneg_q ? -cross_s : cross_s) + jetp_pkg::C_IMAG;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.store_im) count_d = '0;
    else if (cmd_i.upd) count_d = count_inc[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

  assign escape_count_o = count_q;

  `JETP_ASSERT_NEXT(a_upd_counts, cmd_i.upd, count_q != '0)

endmodule

// ===== hw/rtl/julia_escape_time_pixel_core.sv =====
// Top level of the Julia escape-time pixel core.
// Depends on jetp_pkg, jetp_cfg, jetp_ctrl and jetp_dp.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                  Payload
// pixel     in         start_i & !busy_o          column_i[7:0], row_i[6:0]
// result    out        result_valid_o (1 cycle)   escape_count_o[7:0]
// config    in         cfg_valid_i & cfg_ready_o  cfg_index_i[1:0], cfg_data_i[15:0]
//
// A pixel runs n = 1..255 iteration steps. Its row and column start values first go
//   through one restoring divider at one quotient bit a cycle; each step then passes
//   through the multipliers and then the z update.
// One pixel is in flight at a time; busy_o stays high until the strobe cycle is over.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and the offsets and
//   zoom to 80, 60 and 50. The receiver cannot stall: the result is shown for one cycle.
// Config writes are always taken (cfg_ready_o tied high); issue them while idle.
// A zoom of zero is treated as one; an unmapped register index is ignored.

module julia_escape_time_pixel_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel command
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [7:0]                      column_i,
  input  logic [6:0]                      row_i,
  // result strobe
  output logic                            result_valid_o,
  output logic [jetp_pkg::COUNT_W-1:0]    escape_count_o,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jetp_pkg::CFG_W-1:0]      cfg_data_i
);

  jetp_pkg::cfg_t       cfg;
  jetp_pkg::dp_cmd_t    cmd;
  jetp_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // offsets and zoom, read straight by the datapath
  jetp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: divisions, then MUL/UPD pairs until escape or the step limit
  jetp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  // divider, multipliers, z registers and step count
  jetp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .column_i       (column_i),
    .row_i          (row_i),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .escape_count_o (escape_count_o)
  );

endmodule

// ===== bench/julia_escape_time_pixel_core_tb.sv =====
// Self-checking bench for julia_escape_time_pixel_core: pixels in, escape counts out.
// Depends on jetp_pkg for port widths and register indexes; predicts each count itself.
`timescale 1ns / 1ps

module julia_escape_time_pixel_core_tb;

  // Fixed-point constants of the iteration, 24 fraction bits.
  localparam int     FRAC        = 24;
  localparam longint C_RE_FX     = 64'sd4781507;   // 0.285
  localparam longint C_IM_FX     = 64'sd167772;    // 0.01
  localparam longint RADIUS_SQ   = 64'sd4 <<< FRAC;
  localparam longint unsigned SQ_CLAMP = 64'd1 << 28;   // 16.0
  localparam longint unsigned SQ_SAT   = 64'd1 << 32;   // 256.0
  localparam int     STEP_CAP    = 255;
  // Index the block does not map; a write there must change nothing.
  localparam logic [jetp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Run-length limit: sized from the slowest pixel and the longest sender gap.
  localparam int PIXEL_BUDGET  = 1300;
  localparam int CYCLE_LIMIT   = PIXEL_BUDGET * (593 + 700 + 4) * 3;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PHASES = 23;
  localparam int PHASE_PIXELS  = 50;

  // Escape-count predictor plus the queue of counts still owed by the block.
  class escape_count_board;
    logic [jetp_pkg::CFG_W-1:0]   column_offset;
    logic [jetp_pkg::CFG_W-1:0]   row_offset;
    logic [jetp_pkg::CFG_W-1:0]   zoom_divisor;
    logic [jetp_pkg::COUNT_W-1:0] owed_counts[$];
    int unsigned                  failures;

    function new();
      column_offset = 16'd80;
      row_offset    = 16'd60;
      zoom_divisor  = 16'd50;
      failures      = 0;
    endfunction

    function void set_register(logic [jetp_pkg::CFG_IDX_W-1:0] idx,
                               logic [jetp_pkg::CFG_W-1:0] data);
      case (idx)
        jetp_pkg::CFG_COLUMN_OFFSET: column_offset = data;
        jetp_pkg::CFG_ROW_OFFSET:    row_offset    = data;
        jetp_pkg::CFG_ZOOM_DIVISOR:  zoom_divisor  = data;
        default: ;
      endcase
    endfunction

    // (|pix - origin| << 24) / zoom, truncated, then signed.
    function longint start_coord(logic [15:0] pix, logic [15:0] origin, logic [15:0] zoom);
      longint unsigned diff;
      longint unsigned mag;
      diff = (origin > pix) ? origin - pix : pix - origin;
      mag  = (diff << FRAC) / zoom;
      return (origin > pix) ? -longint'(mag) : longint'(mag);
    endfunction

    function longint unsigned square_fx(longint unsigned m);
      if (m >= SQ_CLAMP) return SQ_SAT;
      return (m * m) >> FRAC;
    endfunction

    function logic [jetp_pkg::COUNT_W-1:0] escape_steps(logic [7:0] col, logic [6:0] row);
      logic [15:0]     zoom;
      longint          re;
      longint          im;
      longint          radius;
      longint unsigned mr, mi, sr, si, cr, ci, cross_mag;
      bit              cneg;
      int              steps;
      zoom   = (zoom_divisor == 0) ? 16'd1 : zoom_divisor;
      re     = start_coord({9'd0, row}, row_offset, zoom);
      im     = start_coord({8'd0, col}, column_offset, zoom);
      radius = 0;
      steps  = 0;
      while (steps < STEP_CAP && radius < RADIUS_SQ) begin
        mr        = (re < 0) ? longint'(-re) : longint'(re);
        mi        = (im < 0) ? longint'(-im) : longint'(im);
        sr        = square_fx(mr);
        si        = square_fx(mi);
        cr        = (mr >= SQ_CLAMP) ? SQ_CLAMP : mr;
        ci        = (mi >= SQ_CLAMP) ? SQ_CLAMP : mi;
        cross_mag = (2 * cr * ci) >> FRAC;
        cneg      = (re < 0) != (im < 0);
        im        = (cneg ? -longint'(cross_mag) : longint'(cross_mag)) + C_IM_FX;
        re        = longint'(sr) - longint'(si) + C_RE_FX;
        radius    = longint'(sr + si);
        steps++;
      end
      return steps[jetp_pkg::COUNT_W-1:0];
    endfunction

    function void note_pixel(logic [7:0] col, logic [6:0] row);
      owed_counts.push_back(escape_steps(col, row));
    endfunction

    function void check_result(logic [jetp_pkg::COUNT_W-1:0] actual);
      logic [jetp_pkg::COUNT_W-1:0] want;
      if (owed_counts.size() == 0) begin
        $error("escape_count: result with no pixel outstanding, actual %0d", actual);
        failures++;
        return;
      end
      want = owed_counts.pop_front();
      if (actual !== want) begin
        $error("escape_count mismatch: expected %0d, actual %0d", want, actual);
        failures++;
      end
    endfunction
  endclass

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               start_i     = 1'b0;
  logic [7:0]                         column_i    = '0;
  logic [6:0]                         row_i       = '0;
  logic                               cfg_valid_i = 1'b0;
  logic [jetp_pkg::CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [jetp_pkg::CFG_W-1:0]         cfg_data_i  = '0;
  logic                               busy_o;
  logic                               result_valid_o;
  logic [jetp_pkg::COUNT_W-1:0]       escape_count_o;
  logic                               cfg_ready_o;

  escape_count_board board;
  int  cycle_count = 0;
  bit  steady_phase;    // no sender gaps for the whole phase
  bit  wide_pixels;     // allow coordinates beyond the frame

  julia_escape_time_pixel_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .column_i       (column_i),
    .row_i          (row_i),
    .result_valid_o (result_valid_o),
    .escape_count_o (escape_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back-to-back or short gaps; now and then a long one that lets the
  // core drain and sit idle before the next pixel.
  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 40);
    return $urandom_range(100, 700);
  endfunction

  // One pixel transfer. start_i stays high across back-to-back pixels so it
  // never gets two updates in one time step.
  task automatic send_pixel(logic [7:0] col, logic [6:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    column_i <= col;
    row_i    <= row;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_pixel(col, row);
  endtask

  task automatic send_random_pixel();
    if (wide_pixels && $urandom_range(0, 99) < 40)
      send_pixel(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    else
      send_pixel(8'($urandom_range(0, 159)), 7'($urandom_range(0, 119)));
  endtask

  // Stop issuing pixels and wait until every owed count is back and the core is idle.
  task automatic drain_pixels();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.owed_counts.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  // One register transfer; valid stays up across back-to-back writes.
  task automatic write_register(logic [jetp_pkg::CFG_IDX_W-1:0] idx,
                                logic [jetp_pkg::CFG_W-1:0] data);
    int gap;
    gap = steady_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_register(idx, data);
  endtask

  task automatic load_frame(logic [jetp_pkg::CFG_W-1:0] col_off,
                            logic [jetp_pkg::CFG_W-1:0] row_off,
                            logic [jetp_pkg::CFG_W-1:0] zoom);
    drain_pixels();
    if ($urandom_range(0, 3) == 0) write_register(CFG_UNMAPPED, 16'($urandom()));
    write_register(jetp_pkg::CFG_COLUMN_OFFSET, col_off);
    write_register(jetp_pkg::CFG_ROW_OFFSET, row_off);
    write_register(jetp_pkg::CFG_ZOOM_DIVISOR, zoom);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [jetp_pkg::CFG_W-1:0] edge_or_random(int lo_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < lo_pct) return 16'd0;
    if (r < 2 * lo_pct) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [jetp_pkg::CFG_W-1:0] col_off, row_off, zoom;
    board = new();
    steady_phase = 1'b0;
    wide_pixels  = 1'b0;

    fork
      // Result side: a strobe is taken at the edge that closes its cycle.
      forever begin
        @(posedge clk_i);
        if (rst_ni && result_valid_o) board.check_result(escape_count_o);
      end
    join_none

    fork
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk_i);
          cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    join_none

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset frame: corners, the centre pixel (z starts at zero), the pixels
    // around it and the far edges of both fields, inside and outside the frame.
    send_pixel(8'd0,   7'd0);
    send_pixel(8'd159, 7'd119);
    send_pixel(8'd255, 7'd127);
    send_pixel(8'd80,  7'd60);
    send_pixel(8'd79,  7'd59);
    send_pixel(8'd81,  7'd61);
    send_pixel(8'd0,   7'd127);
    send_pixel(8'd255, 7'd0);
    send_pixel(8'd80,  7'd0);
    send_pixel(8'd0,   7'd60);
    send_pixel(8'd170, 7'd85);

    // Largest offsets and zoom: every start value small and negative.
    load_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(8'd0,   7'd0);
    send_pixel(8'd255, 7'd127);
    send_pixel(8'd128, 7'd64);

    // Zero offsets and zoom of zero (taken as one): big coordinates overflow
    // the square input and saturate; pixel (0,0) starts at the origin.
    load_frame(16'd0, 16'd0, 16'd0);
    @(posedge clk_i);
    write_register(CFG_UNMAPPED, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_pixel(8'd0,   7'd0);
    send_pixel(8'd255, 7'd127);
    send_pixel(8'd16,  7'd0);
    send_pixel(8'd0,   7'd16);
    send_pixel(8'd15,  7'd15);
    send_pixel(8'd1,   7'd1);
    send_pixel(8'd1,   7'd0);

    // Random frames: mostly views near the usual picture so the orbits run
    // long, the rest odd origins and the register extremes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady_phase = ($urandom_range(0, 4) == 0);
      wide_pixels  = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) begin
        col_off = edge_or_random(30);
        row_off = edge_or_random(30);
        zoom    = edge_or_random(25);
      end else begin
        col_off = 16'($urandom_range(40, 120));
        row_off = 16'($urandom_range(30, 90));
        zoom    = 16'($urandom_range(20, 400));
      end
      load_frame(col_off, row_off, zoom);
      for (int i = 0; i < PHASE_PIXELS; i++) send_random_pixel();
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.owed_counts.size() != 0) begin
      $error("escape_count: %0d results never arrived", board.owed_counts.size());
      board.failures++;
    end
    if (board.failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
